FILE: rtl/fwr_pkg.sv
// Shared types, constants and helpers for the firewall rule table.
// No dependencies; every other file in rtl/ uses this package.
package fwr_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int STATUS_W = 3;
  localparam int RIDX_W   = 4;

  // Command codes; code 3 has no meaning and is answered invalid
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CHECK  = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_DELETED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_ACCEPTED = 3'd5,
    ST_REJECTED = 3'd6
  } status_t;

  // Walk pointer operations
  typedef enum logic [1:0] {
    PTR_HOLD  = 2'd0,
    PTR_CLEAR = 2'd1,
    PTR_INCR  = 2'd2
  } ptr_op_t;

  // Source of the reported rule index
  typedef enum logic [1:0] {
    RIDX_ZERO  = 2'd0,
    RIDX_COUNT = 2'd1,
    RIDX_PTR   = 2'd2
  } ridx_sel_t;

  // One stored rule; high bounds equal low bounds for single values
  typedef struct packed {
    logic [ADDR_W-1:0] addr_low;
    logic [ADDR_W-1:0] addr_high;
    logic [PORT_W-1:0] port_high;
    logic [PORT_W-1:0] port_low;
    logic              port_rng;
    logic              addr_rng;
  } entry_t;

  // Controller -> datapath
  typedef struct packed {
    logic      take;        // ready toward the input channel
    ptr_op_t   ptr_op;
    logic      wr_add;      // append the captured rule at the table end
    logic      wr_shift;    // move the entry at ptr down one place
    logic      cnt_inc;
    logic      cnt_dec;
    logic      res_set;
    status_t   res_status;
    ridx_sel_t res_idx_sel;
    logic      load_out;    // push the result into the output register
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic             in_fire;
    logic [CMD_W-1:0] cmd;
    logic             add_bad;
    logic             table_full;
    logic             table_empty;
    logic             hit;
    logic             last;
    logic             out_busy;
  } dp_status_t;

  // Low RIDX_W bits of a table position, zero-extended when narrower
  function automatic logic [RIDX_W-1:0] to_rule_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W+RIDX_W-1:0] ext;
    ext = {{RIDX_W{1'b0}}, idx};
    return ext[RIDX_W-1:0];
  endfunction

endpackage

FILE: rtl/fwr_if.sv
// Valid/ready channel interfaces for the rule table's command and result beats.
// Depends on fwr_pkg for field widths.
interface fwr_in_if;
  logic                          valid;
  logic                          ready;
  logic [fwr_pkg::CMD_W-1:0]     command;
  logic [fwr_pkg::ADDR_W-1:0]    ip_low;
  logic [fwr_pkg::ADDR_W-1:0]    ip_high;
  logic                          ip_is_range;
  logic [fwr_pkg::PORT_W-1:0]    port_low;
  logic [fwr_pkg::PORT_W-1:0]    port_high;
  logic                          port_is_range;
  logic [fwr_pkg::ADDR_W-1:0]    query_address;
  logic [fwr_pkg::PORT_W-1:0]    query_port;

  modport source (
    output valid, command, ip_low, ip_high, ip_is_range, port_low, port_high,
           port_is_range, query_address, query_port,
    input  ready
  );
  modport sink (
    input  valid, command, ip_low, ip_high, ip_is_range, port_low, port_high,
           port_is_range, query_address, query_port,
    output ready
  );
endinterface

interface fwr_out_if;
  logic                          valid;
  logic                          ready;
  logic [fwr_pkg::STATUS_W-1:0]  status;
  logic [fwr_pkg::RIDX_W-1:0]    rule_index;

  modport source (output valid, status, rule_index, input ready);
  modport sink   (input valid, status, rule_index, output ready);
endinterface

FILE: rtl/fwr_datapath.sv
// Rule table datapath: captured command, rule memory, walk pointer, compare
// logic, entry count and output register. Depends on fwr_pkg and fwr_if.
module fwr_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  fwr_in_if.sink                 in_if,
  fwr_out_if.source              out_if,
  input  fwr_pkg::ctrl_cmd_t     cmd,
  output fwr_pkg::dp_status_t    st
);

  // Captured beat
  logic [fwr_pkg::CMD_W-1:0]  cmd_r;
  logic [fwr_pkg::ADDR_W-1:0] alo_r, ahi_r, qa_r;
  logic [fwr_pkg::PORT_W-1:0] plo_r, phi_r, qp_r;
  logic                       arng_r, prng_r;

  // Table state
  fwr_pkg::entry_t            mem [fwr_pkg::TABLE_DEPTH];
  fwr_pkg::entry_t            rd_data_r;
  logic [fwr_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [fwr_pkg::CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [fwr_pkg::CNT_W-1:0]  ptr_m1;
  logic [fwr_pkg::IDX_W-1:0]  rd_addr, wr_addr;
  fwr_pkg::entry_t            wr_data, new_entry;
  logic                       wr_en;

  // Result staging and output register
  fwr_pkg::status_t           res_status_r;
  logic [fwr_pkg::RIDX_W-1:0] res_idx_r, res_idx;
  fwr_pkg::status_t           out_status_r;
  logic [fwr_pkg::RIDX_W-1:0] out_idx_r;
  logic                       out_valid_r, out_valid_nxt;

  logic in_fire;
  logic match, equal;

  assign in_if.ready = cmd.take;
  assign in_fire     = in_if.valid & cmd.take;

  // Capture the beat; a single value uses its low bound as high bound
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_if.command;
      alo_r  <= in_if.ip_low;
      ahi_r  <= in_if.ip_is_range ? in_if.ip_high : in_if.ip_low;
      arng_r <= in_if.ip_is_range;
      plo_r  <= in_if.port_low;
      phi_r  <= in_if.port_is_range ? in_if.port_high : in_if.port_low;
      prng_r <= in_if.port_is_range;
      qa_r   <= in_if.query_address;
      qp_r   <= in_if.query_port;
    end
  end

  // Walk pointer
  always_comb begin
    unique case (cmd.ptr_op)
      fwr_pkg::PTR_CLEAR: ptr_nxt = '0;
      fwr_pkg::PTR_INCR:  ptr_nxt = ptr_r + fwr_pkg::CNT_W'(1);
      default:            ptr_nxt = ptr_r;
    endcase
  end

  assign ptr_m1  = ptr_r - fwr_pkg::CNT_W'(1);
  assign rd_addr = ptr_nxt[fwr_pkg::IDX_W-1:0];

  // Write port: append at count, or shift the read entry down one place
  assign new_entry = '{addr_low: alo_r, addr_high: ahi_r, port_high: phi_r,
                       port_low: plo_r, port_rng: prng_r, addr_rng: arng_r};
  assign wr_en   = cmd.wr_add | cmd.wr_shift;
  assign wr_addr = cmd.wr_add ? count_r[fwr_pkg::IDX_W-1:0] : ptr_m1[fwr_pkg::IDX_W-1:0];
  assign wr_data = cmd.wr_add ? new_entry : rd_data_r;

  // Rule memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) count_nxt = count_r + fwr_pkg::CNT_W'(1);
    else if (cmd.cnt_dec) count_nxt = count_r - fwr_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // Containment test for check, exact compare for delete
  assign match = (qa_r >= rd_data_r.addr_low) && (qa_r <= rd_data_r.addr_high) &&
                 (qp_r >= rd_data_r.port_low) && (qp_r <= rd_data_r.port_high);
  assign equal = (rd_data_r.addr_rng == arng_r) && (rd_data_r.port_rng == prng_r) &&
                 (rd_data_r.addr_low == alo_r) &&
                 (!arng_r || (rd_data_r.addr_high == ahi_r)) &&
                 (rd_data_r.port_low == plo_r) &&
                 (!prng_r || (rd_data_r.port_high == phi_r));

  // Result staging
  always_comb begin
    unique case (cmd.res_idx_sel)
      fwr_pkg::RIDX_COUNT: res_idx = fwr_pkg::to_rule_index(count_r[fwr_pkg::IDX_W-1:0]);
      fwr_pkg::RIDX_PTR:   res_idx = fwr_pkg::to_rule_index(ptr_r[fwr_pkg::IDX_W-1:0]);
      default:             res_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_idx_r    <= res_idx;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_r;
    end
  end

  // Output register: holds a beat until the receiver takes it
  assign out_valid_nxt = cmd.load_out | (out_valid_r & ~out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.rule_index = out_idx_r;

  // Status toward the controller
  assign st.in_fire     = in_fire;
  assign st.cmd         = cmd_r;
  assign st.add_bad     = (arng_r && (alo_r >= ahi_r)) || (prng_r && (plo_r >= phi_r));
  assign st.table_full  = (count_r == fwr_pkg::CNT_W'(fwr_pkg::TABLE_DEPTH));
  assign st.table_empty = (count_r == '0);
  assign st.hit         = (cmd_r == fwr_pkg::CMD_CHECK) ? match : equal;
  assign st.last        = ((ptr_r + fwr_pkg::CNT_W'(1)) == count_r);
  assign st.out_busy    = out_valid_r & ~out_if.ready;

endmodule

FILE: rtl/fwr_ctrl.sv
// Rule table controller: sequences accept, dispatch, table walk, delete
// compaction and result hand-off. Depends on fwr_pkg.
module fwr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fwr_pkg::dp_status_t   st,
  output fwr_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_SCAN     = 5'b00100,
    S_SHIFT    = 5'b01000,
    S_RESP     = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  fwr_pkg::status_t  miss_status;

  assign miss_status = (st.cmd == fwr_pkg::CMD_CHECK) ? fwr_pkg::ST_REJECTED
                                                      : fwr_pkg::ST_NOTFOUND;

  // Next state and datapath commands
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.ptr_op      = fwr_pkg::PTR_HOLD;
    cmd.res_status  = fwr_pkg::ST_INVALID;
    cmd.res_idx_sel = fwr_pkg::RIDX_ZERO;
    unique case (state_r)
      S_IDLE: begin
        // no beat is taken while reset is held
        cmd.take = rst_n;
        if (st.in_fire) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (st.cmd)
          fwr_pkg::CMD_ADD: begin
            cmd.res_set = 1'b1;
            state_nxt   = S_RESP;
            if (st.add_bad) begin
              cmd.res_status = fwr_pkg::ST_INVALID;
            end else if (st.table_full) begin
              cmd.res_status = fwr_pkg::ST_FULL;
            end else begin
              cmd.wr_add      = 1'b1;
              cmd.cnt_inc     = 1'b1;
              cmd.res_status  = fwr_pkg::ST_ADDED;
              cmd.res_idx_sel = fwr_pkg::RIDX_COUNT;
            end
          end
          fwr_pkg::CMD_DELETE, fwr_pkg::CMD_CHECK: begin
            if (st.table_empty) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = miss_status;
              state_nxt      = S_RESP;
            end else begin
              // read of entry 0 issued now, compared next cycle
              cmd.ptr_op = fwr_pkg::PTR_CLEAR;
              state_nxt  = S_SCAN;
            end
          end
          default: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = fwr_pkg::ST_INVALID;
            state_nxt      = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        if (st.hit) begin
          cmd.res_set     = 1'b1;
          cmd.res_idx_sel = fwr_pkg::RIDX_PTR;
          if (st.cmd == fwr_pkg::CMD_CHECK) begin
            cmd.res_status = fwr_pkg::ST_ACCEPTED;
            state_nxt      = S_RESP;
          end else begin
            cmd.res_status = fwr_pkg::ST_DELETED;
            if (st.last) begin
              cmd.cnt_dec = 1'b1;
              state_nxt   = S_RESP;
            end else begin
              cmd.ptr_op = fwr_pkg::PTR_INCR;
              state_nxt  = S_SHIFT;
            end
          end
        end else if (st.last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = miss_status;
          state_nxt      = S_RESP;
        end else begin
          cmd.ptr_op = fwr_pkg::PTR_INCR;
        end
      end
      S_SHIFT: begin
        // entry at ptr moves to ptr-1
        cmd.wr_shift = 1'b1;
        if (st.last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_RESP;
        end else begin
          cmd.ptr_op = fwr_pkg::PTR_INCR;
        end
      end
      S_RESP: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: rtl/firewall_rule_table_match_top.sv
// Top level of the first-match firewall rule table.
// Depends on fwr_pkg, fwr_if, fwr_ctrl and fwr_datapath.
//
// Usage:
//   in_if  : command beats (add, delete, check) with rule bounds, range flags
//            and the query address and port. Accepted when valid and ready
//            are both high; ready is high only while the block is idle.
//   out_if : one result beat per command: status and rule index. The beat
//            sits in an output register until the receiver takes it.
// Timing:
//   Add and invalid commands go from accept through dispatch and the response
//   state back to idle. Check and delete walk the table one entry per cycle
//   through the rule memory's single registered read port; delete then moves
//   each later entry up one place per cycle. The result is staged, then loaded
//   into the output register once that register is free.
// Reset (rst_n, synchronous, active low) empties the table at once; stored
// rules are not cleared, since entries at or beyond the count are never read.
// When the receiver stalls, the next command is still taken and processed;
// its result waits until the output register frees up.
module firewall_rule_table_match_top (
  input  logic        clk,
  input  logic        rst_n,
  fwr_in_if.sink      in_if,
  fwr_out_if.source   out_if
);

  fwr_pkg::ctrl_cmd_t  ctrl_cmd;
  fwr_pkg::dp_status_t dp_st;

  fwr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (dp_st),
    .cmd   (ctrl_cmd)
  );

  fwr_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cmd    (ctrl_cmd),
    .st     (dp_st)
  );

  // One command in flight: no new beat right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input accepted while a command is still in flight");

  // Never append into a full table
  a_no_add_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.wr_add |-> !dp_st.table_full)
    else $error("append issued with the table full");

  // A delete only completes on a non-empty table
  a_no_dec_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.cnt_dec |-> !dp_st.table_empty)
    else $error("entry count decremented below zero");

  // Result hand-off never overwrites an untaken beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.load_out |-> !dp_st.out_busy)
    else $error("output register loaded while a beat is still waiting");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for firewall_rule_table_match_top: a directed command table, then
// random add/delete/check/unused beats. Results are listed or predicted by a table copy.
// Depends on fwr_pkg and the fwr_in_if / fwr_out_if interfaces in rtl/.
module testbench;

  localparam logic [fwr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam bit KNOWN         = 1'b1;
  localparam bit BY_PRED       = 1'b0;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int LONG_HOLD     = 400;
  localparam int TAIL_CYCLES   = 40;

  typedef struct packed {
    logic [fwr_pkg::CMD_W-1:0]  cmd;
    logic [fwr_pkg::ADDR_W-1:0] ip_low;
    logic [fwr_pkg::ADDR_W-1:0] ip_high;
    logic                       ip_rng;
    logic [fwr_pkg::PORT_W-1:0] port_low;
    logic [fwr_pkg::PORT_W-1:0] port_high;
    logic                       port_rng;
    logic [fwr_pkg::ADDR_W-1:0] qaddr;
    logic [fwr_pkg::PORT_W-1:0] qport;
  } acl_cmd_t;

  typedef struct packed {
    fwr_pkg::status_t           status;
    logic [fwr_pkg::RIDX_W-1:0] idx;
  } acl_res_t;

  typedef struct {
    acl_cmd_t c;
    int       reps;
    bit       typed;
    acl_res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  fwr_in_if  in_ch();
  fwr_out_if out_ch();

  firewall_rule_table_match_top DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // Local copy of the rule table
  logic [fwr_pkg::ADDR_W-1:0] acl_alo [fwr_pkg::TABLE_DEPTH];
  logic [fwr_pkg::ADDR_W-1:0] acl_ahi [fwr_pkg::TABLE_DEPTH];
  logic [fwr_pkg::PORT_W-1:0] acl_plo [fwr_pkg::TABLE_DEPTH];
  logic [fwr_pkg::PORT_W-1:0] acl_phi [fwr_pkg::TABLE_DEPTH];
  logic [1:0]                 acl_fl  [fwr_pkg::TABLE_DEPTH];
  int                         acl_cnt = 0;

  acl_res_t results_due[$];
  dir_row_t dir_rows[$];
  int       n_fail    = 0;
  bit       in_gap_on = 1'b1;
  bit       rx_gap_on = 1'b1;
  int       rx_hold   = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one command to the local table and return its result
  function automatic acl_res_t acl_apply(input acl_cmd_t c);
    acl_res_t                   r;
    logic [fwr_pkg::ADDR_W-1:0] ahi;
    logic [fwr_pkg::PORT_W-1:0] phi;
    logic [1:0]                 fl;
    int                         hit;
    int                         i;
    ahi = c.ip_rng ? c.ip_high : c.ip_low;
    phi = c.port_rng ? c.port_high : c.port_low;
    fl = {c.port_rng, c.ip_rng};
    r.status = fwr_pkg::ST_INVALID;
    r.idx = '0;
    hit = -1;
    case (c.cmd)
      fwr_pkg::CMD_ADD: begin
        if ((c.ip_rng && c.ip_low >= ahi) || (c.port_rng && c.port_low >= phi)) begin
          r.status = fwr_pkg::ST_INVALID;
        end else if (acl_cnt >= fwr_pkg::TABLE_DEPTH) begin
          r.status = fwr_pkg::ST_FULL;
        end else begin
          acl_alo[acl_cnt] = c.ip_low;
          acl_ahi[acl_cnt] = ahi;
          acl_plo[acl_cnt] = c.port_low;
          acl_phi[acl_cnt] = phi;
          acl_fl[acl_cnt] = fl;
          r.status = fwr_pkg::ST_ADDED;
          r.idx = fwr_pkg::RIDX_W'(acl_cnt);
          acl_cnt++;
        end
      end
      fwr_pkg::CMD_DELETE: begin
        // exact match; a high bound only counts when its range flag is set
        for (i = 0; i < acl_cnt; i++) begin
          if (hit < 0 && acl_fl[i] == fl && acl_alo[i] == c.ip_low &&
              (!fl[0] || acl_ahi[i] == ahi) && acl_plo[i] == c.port_low &&
              (!fl[1] || acl_phi[i] == phi))
            hit = i;
        end
        if (hit < 0) begin
          r.status = fwr_pkg::ST_NOTFOUND;
        end else begin
          for (i = hit; i < acl_cnt - 1; i++) begin
            acl_alo[i] = acl_alo[i+1];
            acl_ahi[i] = acl_ahi[i+1];
            acl_plo[i] = acl_plo[i+1];
            acl_phi[i] = acl_phi[i+1];
            acl_fl[i] = acl_fl[i+1];
          end
          acl_cnt--;
          r.status = fwr_pkg::ST_DELETED;
          r.idx = fwr_pkg::RIDX_W'(hit);
        end
      end
      fwr_pkg::CMD_CHECK: begin
        // first rule whose inclusive ranges hold the query
        for (i = 0; i < acl_cnt; i++) begin
          if (hit < 0 && c.qaddr >= acl_alo[i] && c.qaddr <= acl_ahi[i] &&
              c.qport >= acl_plo[i] && c.qport <= acl_phi[i])
            hit = i;
        end
        if (hit < 0) begin
          r.status = fwr_pkg::ST_REJECTED;
        end else begin
          r.status = fwr_pkg::ST_ACCEPTED;
          r.idx = fwr_pkg::RIDX_W'(hit);
        end
      end
      default: r.status = fwr_pkg::ST_INVALID;
    endcase
    return r;
  endfunction

  function automatic acl_cmd_t mk(input logic [fwr_pkg::CMD_W-1:0] cmd,
                                  input logic [fwr_pkg::ADDR_W-1:0] ilo, ihi,
                                  input logic irng,
                                  input logic [fwr_pkg::PORT_W-1:0] plo, phi,
                                  input logic prng,
                                  input logic [fwr_pkg::ADDR_W-1:0] qa,
                                  input logic [fwr_pkg::PORT_W-1:0] qp);
    acl_cmd_t c;
    c.cmd = cmd;
    c.ip_low = ilo;
    c.ip_high = ihi;
    c.ip_rng = irng;
    c.port_low = plo;
    c.port_high = phi;
    c.port_rng = prng;
    c.qaddr = qa;
    c.qport = qp;
    return c;
  endfunction

  task automatic dir_row(input acl_cmd_t c, input int reps, input bit typed,
                         input fwr_pkg::status_t st, input int idx);
    dir_row_t d;
    d.c = c;
    d.reps = reps;
    d.typed = typed;
    d.want.status = st;
    d.want.idx = fwr_pkg::RIDX_W'(idx);
    dir_rows.push_back(d);
  endtask

  function automatic int pause_len(input bit on);
    return on ? int'($urandom_range(0, 11)) : 0;
  endfunction

  // Address and port pools: full random, small clusters and the extremes
  function automatic logic [fwr_pkg::ADDR_W-1:0] pick_addr();
    logic [fwr_pkg::ADDR_W-1:0] a;
    case ($urandom_range(0, 4))
      0: a = $urandom;
      1: a = 32'hC0A8_0100 | $urandom_range(0, 63);
      2: a = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      3: a = 32'h0A00_0000 + $urandom_range(0, 15);
      default: a = 32'hFFFF_FFF0 | $urandom_range(0, 15);
    endcase
    return a;
  endfunction

  function automatic logic [fwr_pkg::PORT_W-1:0] pick_port();
    logic [fwr_pkg::PORT_W-1:0] p;
    case ($urandom_range(0, 3))
      0: p = fwr_pkg::PORT_W'($urandom);
      1: p = fwr_pkg::PORT_W'($urandom_range(0, 3));
      2: p = fwr_pkg::PORT_W'($urandom_range(80, 90));
      default: p = 16'hFFFF - fwr_pkg::PORT_W'($urandom_range(0, 3));
    endcase
    return p;
  endfunction

  // High bound at or above lo, clipped at maxv; a zero span gives an empty range
  function automatic longint unsigned upper_bound(input longint unsigned lo, maxv);
    longint unsigned s;
    longint unsigned res;
    case ($urandom_range(0, 3))
      0: s = 64'($urandom_range(0, 8));
      1: s = 64'($urandom_range(0, 4096));
      2: s = maxv;
      default: s = {32'h0, $urandom} % (maxv + 1);
    endcase
    res = lo + s;
    if (res > maxv) res = maxv;
    return res;
  endfunction

  // A value in [lo, hi], bounds included often
  function automatic longint unsigned pick_between(input longint unsigned lo, hi);
    longint unsigned pick;
    longint unsigned res;
    case ($urandom_range(0, 3))
      0: res = lo;
      1: res = hi;
      default: begin
        pick = {$urandom, $urandom};
        res = lo + pick % (hi - lo + 1);
      end
    endcase
    return res;
  endfunction

  function automatic acl_cmd_t junk_cmd(input logic [fwr_pkg::CMD_W-1:0] cmd);
    acl_cmd_t c;
    c.cmd = cmd;
    c.ip_low = $urandom;
    c.ip_high = $urandom;
    c.ip_rng = 1'($urandom_range(0, 1));
    c.port_low = fwr_pkg::PORT_W'($urandom);
    c.port_high = fwr_pkg::PORT_W'($urandom);
    c.port_rng = 1'($urandom_range(0, 1));
    c.qaddr = $urandom;
    c.qport = fwr_pkg::PORT_W'($urandom);
    return c;
  endfunction

  function automatic acl_cmd_t rand_rule(input logic [fwr_pkg::CMD_W-1:0] cmd);
    acl_cmd_t c;
    c = junk_cmd(cmd);
    c.ip_low = pick_addr();
    c.port_low = pick_port();
    if (c.ip_rng)
      c.ip_high = fwr_pkg::ADDR_W'(upper_bound(64'(c.ip_low), 64'hFFFF_FFFF));
    if (c.port_rng)
      c.port_high = fwr_pkg::PORT_W'(upper_bound(64'(c.port_low), 64'hFFFF));
    // now and then a reversed or empty range
    if ($urandom_range(0, 11) == 0) begin
      if ($urandom_range(0, 1)) begin
        c.ip_rng = 1'b1;
        c.ip_high = c.ip_low - fwr_pkg::ADDR_W'($urandom_range(0, 2));
      end else begin
        c.port_rng = 1'b1;
        c.port_high = c.port_low - fwr_pkg::PORT_W'($urandom_range(0, 2));
      end
    end
    return c;
  endfunction

  // Mostly deletes of stored rules, with junk in unused high bounds
  function automatic acl_cmd_t gen_delete();
    acl_cmd_t c;
    int       k;
    if (acl_cnt > 0 && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, acl_cnt - 1);
      c = junk_cmd(fwr_pkg::CMD_DELETE);
      c.ip_rng = acl_fl[k][0];
      c.port_rng = acl_fl[k][1];
      c.ip_low = acl_alo[k];
      c.port_low = acl_plo[k];
      if (c.ip_rng) c.ip_high = acl_ahi[k];
      if (c.port_rng) c.port_high = acl_phi[k];
    end else begin
      c = rand_rule(fwr_pkg::CMD_DELETE);
    end
    return c;
  endfunction

  // Mostly queries that fall inside a stored rule
  function automatic acl_cmd_t gen_check();
    acl_cmd_t c;
    int       k;
    c = junk_cmd(fwr_pkg::CMD_CHECK);
    if (acl_cnt > 0 && $urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, acl_cnt - 1);
      c.qaddr = fwr_pkg::ADDR_W'(pick_between(64'(acl_alo[k]), 64'(acl_ahi[k])));
      c.qport = fwr_pkg::PORT_W'(pick_between(64'(acl_plo[k]), 64'(acl_phi[k])));
    end else begin
      c.qaddr = pick_addr();
      c.qport = pick_port();
    end
    return c;
  endfunction

  // Offer one command beat; valid stays high on return so back-to-back beats need no gap
  task automatic send_cmd(input acl_cmd_t c, input bit typed, input acl_res_t want);
    int       gap;
    acl_res_t r;
    gap = pause_len(in_gap_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= c.cmd;
    in_ch.ip_low <= c.ip_low;
    in_ch.ip_high <= c.ip_high;
    in_ch.ip_is_range <= c.ip_rng;
    in_ch.port_low <= c.port_low;
    in_ch.port_high <= c.port_high;
    in_ch.port_is_range <= c.port_rng;
    in_ch.query_address <= c.qaddr;
    in_ch.query_port <= c.qport;
    do @(posedge clk); while (!in_ch.ready);
    r = acl_apply(c);
    results_due.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Command side
  initial begin : cmd_source
    int       p;
    int       n;
    int       r;
    int       k;
    int       w_add;
    int       w_del;
    acl_cmd_t c;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= fwr_pkg::CMD_ADD;
    in_ch.ip_low <= '0;
    in_ch.ip_high <= '0;
    in_ch.ip_is_range <= 1'b0;
    in_ch.port_low <= '0;
    in_ch.port_high <= '0;
    in_ch.port_is_range <= 1'b0;
    in_ch.query_address <= '0;
    in_ch.query_port <= '0;

    // empty table: nothing to match or delete
    dir_row(mk(fwr_pkg::CMD_CHECK, 32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 32'h0102_0304, 16'd80),
            1, KNOWN, fwr_pkg::ST_REJECTED, 0);
    dir_row(mk(fwr_pkg::CMD_DELETE, 32'h0A00_0001, 32'h0, 0, 16'd80, 16'h0, 0, 32'h0, 16'h0),
            1, KNOWN, fwr_pkg::ST_NOTFOUND, 0);
    // empty address range, reversed port range, undefined command
    dir_row(mk(fwr_pkg::CMD_ADD, 32'h5, 32'h5, 1, 16'd1, 16'd2, 1, 32'h0, 16'h0),
            1, KNOWN, fwr_pkg::ST_INVALID, 0);
    dir_row(mk(fwr_pkg::CMD_ADD, 32'h0A00_0000, 32'h0A00_00FF, 1, 16'd9000, 16'd80, 1,
               32'h0, 16'h0), 1, KNOWN, fwr_pkg::ST_INVALID, 0);
    dir_row(mk(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 16'hFFFF, 16'hFFFF, 1,
               32'hFFFF_FFFF, 16'hFFFF), 1, KNOWN, fwr_pkg::ST_INVALID, 0);
    // extremes: single 0/0, the whole space, a subnet on one port
    dir_row(mk(fwr_pkg::CMD_ADD, 32'h0, 32'hFFFF_FFFF, 0, 16'h0, 16'hFFFF, 0,
               32'hFFFF_FFFF, 16'hFFFF), 1, KNOWN, fwr_pkg::ST_ADDED, 0);
    dir_row(mk(fwr_pkg::CMD_ADD, 32'h0, 32'hFFFF_FFFF, 1, 16'h0, 16'hFFFF, 1, 32'h0, 16'h0),
            1, KNOWN, fwr_pkg::ST_ADDED, 1);
    dir_row(mk(fwr_pkg::CMD_ADD, 32'hC0A8_0100, 32'hC0A8_01FF, 1, 16'd443, 16'h0, 0,
               32'h0, 16'h0), 1, KNOWN, fwr_pkg::ST_ADDED, 2);
    dir_row(mk(fwr_pkg::CMD_CHECK, 32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 32'h0, 16'h0),
            1, KNOWN, fwr_pkg::ST_ACCEPTED, 0);
    dir_row(mk(fwr_pkg::CMD_CHECK, 32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 32'hFFFF_FFFF, 16'hFFFF),
            1, KNOWN, fwr_pkg::ST_ACCEPTED, 1);
    dir_row(mk(fwr_pkg::CMD_CHECK, 32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 32'hC0A8_01FF, 16'd443),
            1, BY_PRED, fwr_pkg::ST_ADDED, 0);
    // range flags differ from the 0/0 and whole-space rules; the subnet rule has other bounds
    dir_row(mk(fwr_pkg::CMD_DELETE, 32'h0, 32'h0, 1, 16'h0, 16'h0, 0, 32'h0, 16'h0),
            1, KNOWN, fwr_pkg::ST_NOTFOUND, 0);
    // unused high bounds take no part in the match
    dir_row(mk(fwr_pkg::CMD_DELETE, 32'h0, 32'h1234_5678, 0, 16'h0, 16'hABCD, 0, 32'h0, 16'h0),
            1, KNOWN, fwr_pkg::ST_DELETED, 0);
    dir_row(mk(fwr_pkg::CMD_DELETE, 32'h0, 32'hFFFF_FFFF, 1, 16'h0, 16'hFFFF, 1, 32'h0, 16'h0),
            1, KNOWN, fwr_pkg::ST_DELETED, 0);
    dir_row(mk(fwr_pkg::CMD_CHECK, 32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 32'hC0A8_0107, 16'd443),
            1, BY_PRED, fwr_pkg::ST_ADDED, 0);
    dir_row(mk(fwr_pkg::CMD_CHECK, 32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 32'hC0A8_0107, 16'd444),
            1, KNOWN, fwr_pkg::ST_REJECTED, 0);
    // fill the table, then a valid add (full) and a bad one (invalid wins)
    dir_row(mk(fwr_pkg::CMD_ADD, 32'h0A00_0001, 32'h0, 0, 16'd80, 16'h0, 0, 32'h0, 16'h0),
            15, BY_PRED, fwr_pkg::ST_ADDED, 0);
    dir_row(mk(fwr_pkg::CMD_ADD, 32'h0A00_0002, 32'h0, 0, 16'd22, 16'h0, 0, 32'h0, 16'h0),
            1, KNOWN, fwr_pkg::ST_FULL, 0);
    dir_row(mk(fwr_pkg::CMD_ADD, 32'h0A00_0009, 32'h0A00_0003, 1, 16'd22, 16'h0, 0,
               32'h0, 16'h0), 1, KNOWN, fwr_pkg::ST_INVALID, 0);
    dir_row(mk(fwr_pkg::CMD_CHECK, 32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 32'h0A00_0001, 16'd80),
            1, BY_PRED, fwr_pkg::ST_ADDED, 0);
    dir_row(mk(fwr_pkg::CMD_DELETE, 32'h0A00_0001, 32'h0, 0, 16'd80, 16'h0, 0, 32'h0, 16'h0),
            1, BY_PRED, fwr_pkg::ST_ADDED, 0);
    dir_row(mk(fwr_pkg::CMD_CHECK, 32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 32'hFFFF_FFFF, 16'h0),
            1, KNOWN, fwr_pkg::ST_REJECTED, 0);
    // empty it again; the last duplicate delete finds nothing
    dir_row(mk(fwr_pkg::CMD_DELETE, 32'h0A00_0001, 32'h0, 0, 16'd80, 16'h0, 0, 32'h0, 16'h0),
            15, BY_PRED, fwr_pkg::ST_ADDED, 0);
    dir_row(mk(fwr_pkg::CMD_DELETE, 32'hC0A8_0100, 32'hC0A8_01FF, 1, 16'd443, 16'h0, 0,
               32'h0, 16'h0), 1, KNOWN, fwr_pkg::ST_DELETED, 0);
    dir_row(mk(fwr_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h0, 0, 16'hFFFF, 16'h0, 0, 32'h0, 16'h0),
            1, KNOWN, fwr_pkg::ST_ADDED, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < dir_rows.size(); k++) begin
      repeat (dir_rows[k].reps) send_cmd(dir_rows[k].c, dir_rows[k].typed, dir_rows[k].want);
    end
    drain();

    // Random phases: add-heavy, balanced, delete-heavy in turn
    for (p = 0; p < RANDOM_PHASES; p++) begin
      in_gap_on = (p % 3 != 1);
      rx_gap_on = (p % 4 != 2);
      // long receiver stall while beats keep coming back to back
      if (p == 1) rx_hold = LONG_HOLD;
      case (p % 3)
        0: begin w_add = 60; w_del = 15; end
        1: begin w_add = 35; w_del = 25; end
        default: begin w_add = 15; w_del = 50; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) c = junk_cmd(CMD_UNUSED);
        else if (r < 3 + w_add) c = rand_rule(fwr_pkg::CMD_ADD);
        else if (r < 3 + w_add + w_del) c = gen_delete();
        else c = gen_check();
        send_cmd(c, BY_PRED, '0);
      end
      if (p == 3) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side: random stalls, compare each beat with the oldest expectation
  initial begin : result_sink
    int       n;
    acl_res_t due;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
      end else begin
        n = pause_len(rx_gap_on);
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d index %0d", $time,
                 out_ch.status, out_ch.rule_index);
        n_fail++;
      end else begin
        due = results_due.pop_front();
        if (out_ch.status !== due.status) begin
          $display("%0t: status mismatch, expected %0d got %0d", $time, due.status,
                   out_ch.status);
          n_fail++;
        end
        if (out_ch.rule_index !== due.idx) begin
          $display("%0t: rule index mismatch, expected %0d got %0d", $time, due.idx,
                   out_ch.rule_index);
          n_fail++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fwr_pkg.sv
rtl/fwr_if.sv
rtl/fwr_datapath.sv
rtl/fwr_ctrl.sv
rtl/firewall_rule_table_match_top.sv
bench/testbench.sv
